// ===== src/ucw_pkg.sv =====
// ucw_pkg: shared types, width codes and the non-spacing interval table
// for the column width pipeline. depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package ucw_pkg;

  localparam int CP_W = 21;
  localparam int SPAN_HELD = 142;
  localparam int IDX_W = $clog2(SPAN_HELD + 1);
  localparam int TABLE_ENTRIES_DEF = 142;

  // result codes, two's complement on three bits
  localparam logic signed [2:0] WIDTH_CTRL = -3'sd1;
  localparam logic signed [2:0] WIDTH_ZERO = 3'sd0;
  localparam logic signed [2:0] WIDTH_ONE  = 3'sd1;
  localparam logic signed [2:0] WIDTH_TWO  = 3'sd2;

  typedef struct packed {
    logic [CP_W-1:0] lo;
    logic [CP_W-1:0] hi;
  } ucw_span_t;

  // search state carried from one step to the next
  typedef struct packed {
    logic [CP_W-1:0]  cp;
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
    logic             found;
  } ucw_srch_t;

  // sorted, disjoint non-spacing intervals
  localparam ucw_span_t SPANS [SPAN_HELD] = '{
    '{21'h00300, 21'h0036F}, '{21'h00483, 21'h00486}, '{21'h00488, 21'h00489},
    '{21'h00591, 21'h005BD}, '{21'h005BF, 21'h005BF}, '{21'h005C1, 21'h005C2},
    '{21'h005C4, 21'h005C5}, '{21'h005C7, 21'h005C7}, '{21'h00600, 21'h00603},
    '{21'h00610, 21'h00615}, '{21'h0064B, 21'h0065E}, '{21'h00670, 21'h00670},
    '{21'h006D6, 21'h006E4}, '{21'h006E7, 21'h006E8}, '{21'h006EA, 21'h006ED},
    '{21'h0070F, 21'h0070F}, '{21'h00711, 21'h00711}, '{21'h00730, 21'h0074A},
    '{21'h007A6, 21'h007B0}, '{21'h007EB, 21'h007F3}, '{21'h00901, 21'h00902},
    '{21'h0093C, 21'h0093C}, '{21'h00941, 21'h00948}, '{21'h0094D, 21'h0094D},
    '{21'h00951, 21'h00954}, '{21'h00962, 21'h00963}, '{21'h00981, 21'h00981},
    '{21'h009BC, 21'h009BC}, '{21'h009C1, 21'h009C4}, '{21'h009CD, 21'h009CD},
    '{21'h009E2, 21'h009E3}, '{21'h00A01, 21'h00A02}, '{21'h00A3C, 21'h00A3C},
    '{21'h00A41, 21'h00A42}, '{21'h00A47, 21'h00A48}, '{21'h00A4B, 21'h00A4D},
    '{21'h00A70, 21'h00A71}, '{21'h00A81, 21'h00A82}, '{21'h00ABC, 21'h00ABC},
    '{21'h00AC1, 21'h00AC5}, '{21'h00AC7, 21'h00AC8}, '{21'h00ACD, 21'h00ACD},
    '{21'h00AE2, 21'h00AE3}, '{21'h00B01, 21'h00B01}, '{21'h00B3C, 21'h00B3C},
    '{21'h00B3F, 21'h00B3F}, '{21'h00B41, 21'h00B43}, '{21'h00B4D, 21'h00B4D},
    '{21'h00B56, 21'h00B56}, '{21'h00B82, 21'h00B82}, '{21'h00BC0, 21'h00BC0},
    '{21'h00BCD, 21'h00BCD}, '{21'h00C3E, 21'h00C40}, '{21'h00C46, 21'h00C48},
    '{21'h00C4A, 21'h00C4D}, '{21'h00C55, 21'h00C56}, '{21'h00CBC, 21'h00CBC},
    '{21'h00CBF, 21'h00CBF}, '{21'h00CC6, 21'h00CC6}, '{21'h00CCC, 21'h00CCD},
    '{21'h00CE2, 21'h00CE3}, '{21'h00D41, 21'h00D43}, '{21'h00D4D, 21'h00D4D},
    '{21'h00DCA, 21'h00DCA}, '{21'h00DD2, 21'h00DD4}, '{21'h00DD6, 21'h00DD6},
    '{21'h00E31, 21'h00E31}, '{21'h00E34, 21'h00E3A}, '{21'h00E47, 21'h00E4E},
    '{21'h00EB1, 21'h00EB1}, '{21'h00EB4, 21'h00EB9}, '{21'h00EBB, 21'h00EBC},
    '{21'h00EC8, 21'h00ECD}, '{21'h00F18, 21'h00F19}, '{21'h00F35, 21'h00F35},
    '{21'h00F37, 21'h00F37}, '{21'h00F39, 21'h00F39}, '{21'h00F71, 21'h00F7E},
    '{21'h00F80, 21'h00F84}, '{21'h00F86, 21'h00F87}, '{21'h00F90, 21'h00F97},
    '{21'h00F99, 21'h00FBC}, '{21'h00FC6, 21'h00FC6}, '{21'h0102D, 21'h01030},
    '{21'h01032, 21'h01032}, '{21'h01036, 21'h01037}, '{21'h01039, 21'h01039},
    '{21'h01058, 21'h01059}, '{21'h01160, 21'h011FF}, '{21'h0135F, 21'h0135F},
    '{21'h01712, 21'h01714}, '{21'h01732, 21'h01734}, '{21'h01752, 21'h01753},
    '{21'h01772, 21'h01773}, '{21'h017B4, 21'h017B5}, '{21'h017B7, 21'h017BD},
    '{21'h017C6, 21'h017C6}, '{21'h017C9, 21'h017D3}, '{21'h017DD, 21'h017DD},
    '{21'h0180B, 21'h0180D}, '{21'h018A9, 21'h018A9}, '{21'h01920, 21'h01922},
    '{21'h01927, 21'h01928}, '{21'h01932, 21'h01932}, '{21'h01939, 21'h0193B},
    '{21'h01A17, 21'h01A18}, '{21'h01B00, 21'h01B03}, '{21'h01B34, 21'h01B34},
    '{21'h01B36, 21'h01B3A}, '{21'h01B3C, 21'h01B3C}, '{21'h01B42, 21'h01B42},
    '{21'h01B6B, 21'h01B73}, '{21'h01DC0, 21'h01DCA}, '{21'h01DFE, 21'h01DFF},
    '{21'h0200B, 21'h0200F}, '{21'h0202A, 21'h0202E}, '{21'h02060, 21'h02063},
    '{21'h0206A, 21'h0206F}, '{21'h020D0, 21'h020EF}, '{21'h0302A, 21'h0302F},
    '{21'h03099, 21'h0309A}, '{21'h0A806, 21'h0A806}, '{21'h0A80B, 21'h0A80B},
    '{21'h0A825, 21'h0A826}, '{21'h0FB1E, 21'h0FB1E}, '{21'h0FE00, 21'h0FE0F},
    '{21'h0FE20, 21'h0FE23}, '{21'h0FEFF, 21'h0FEFF}, '{21'h0FFF9, 21'h0FFFB},
    '{21'h10A01, 21'h10A03}, '{21'h10A05, 21'h10A06}, '{21'h10A0C, 21'h10A0F},
    '{21'h10A38, 21'h10A3A}, '{21'h10A3F, 21'h10A3F}, '{21'h1D167, 21'h1D169},
    '{21'h1D173, 21'h1D182}, '{21'h1D185, 21'h1D18B}, '{21'h1D1AA, 21'h1D1AD},
    '{21'h1D242, 21'h1D244}, '{21'hE0001, 21'hE0001}, '{21'hE0020, 21'hE007F},
    '{21'hE0100, 21'hE01EF}
  };

endpackage
`default_nettype wire

// ===== src/unicode_column_width.sv =====
// unicode_column_width: top level of the terminal column width pipeline.
// depends on ucw_pkg, ucw_search_stage and ucw_classify.
`timescale 1ns / 1ps
`default_nettype none
// Measures one code point per item and returns its terminal column width:
// -1 for C0/C1 controls and DEL, 0 for NUL and for anything inside the
// non-spacing interval table, 2 for the East Asian wide and fullwidth ranges
// (planes 2 and 3 only while wide_planes_enable is set), 1 otherwise.
// The table lookup is a binary search laid out as one register stage per
// halving step, clog2(entries+1) stages (eight for the full 142-entry table),
// followed by one classification stage that drives the output register.
// A new item is taken every cycle and results come out one a cycle in input
// order while out_ready stays high. Each stage holds its item while the
// stage after it is full, so back-pressure on out_ready ripples back to
// in_ready without dropping anything. The wide planes register resets to 1
// and is written through cfg_we / cfg_wdata; the user must write it only
// while the pipeline is empty, as the block itself does not enforce this.
module unicode_column_width #(
  parameter int TABLE_ENTRIES = ucw_pkg::TABLE_ENTRIES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [20:0] code_point,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic signed [2:0] column_width
);

  // searched span count: clipped to what the table holds, never below one
  localparam int SPAN_USE = (TABLE_ENTRIES < 1) ? 1 :
                            ((TABLE_ENTRIES > ucw_pkg::SPAN_HELD) ? ucw_pkg::SPAN_HELD
                                                                 : TABLE_ENTRIES);
  // worst case halving steps for that many spans
  localparam int STEPS = $clog2(SPAN_USE + 1);

  logic               wide_planes_enable;
  ucw_pkg::ucw_srch_t srch  [STEPS+1];
  logic               valid [STEPS+1];
  logic               ready [STEPS+1];

  // planes 2 and 3 wide flag, single configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      wide_planes_enable <= 1'b1;
    end else if (cfg_we) begin
      wide_planes_enable <= cfg_wdata;
    end
  end

  // search starts over the whole used table, nothing found yet
  always_comb begin
    srch[0].cp    = code_point;
    srch[0].lo    = '0;
    srch[0].hi    = ucw_pkg::IDX_W'(SPAN_USE);
    srch[0].found = 1'b0;
  end
  assign valid[0] = in_valid;
  assign in_ready = ready[0];

  // one stage per halving step
  for (genvar i = 0; i < STEPS; i++) begin : g_step
    ucw_search_stage u_step (
      .clk        (clk),
      .rst        (rst),
      .up_valid   (valid[i]),
      .up_ready   (ready[i]),
      .up_data    (srch[i]),
      .down_valid (valid[i+1]),
      .down_ready (ready[i+1]),
      .down_data  (srch[i+1])
    );
  end

  // final decision and output register
  ucw_classify u_classify (
    .clk          (clk),
    .rst          (rst),
    .wide_en      (wide_planes_enable),
    .up_valid     (valid[STEPS]),
    .up_ready     (ready[STEPS]),
    .up_data      (srch[STEPS]),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .column_width (column_width)
  );

endmodule
`default_nettype wire

// ===== src/ucw_search_stage.sv =====
// ucw_search_stage: one registered step of the interval binary search.
// depends on ucw_pkg for the search state type and the interval table.
`timescale 1ns / 1ps
`default_nettype none
module ucw_search_stage (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              up_valid,
  output logic                   up_ready,
  input  wire ucw_pkg::ucw_srch_t up_data,
  output logic                   down_valid,
  input  wire logic              down_ready,
  output ucw_pkg::ucw_srch_t     down_data
);

  logic [ucw_pkg::IDX_W:0]   sum;
  logic [ucw_pkg::IDX_W-1:0] mid;
  ucw_pkg::ucw_span_t        span;
  ucw_pkg::ucw_srch_t        step_next;
  logic                      load;

  assign up_ready = !down_valid || down_ready;
  assign load     = up_valid && up_ready;

  always_comb begin
    sum       = {1'b0, up_data.lo} + {1'b0, up_data.hi};
    mid       = sum[ucw_pkg::IDX_W:1];
    span      = ucw_pkg::SPANS[mid];
    step_next = up_data;
    // a finished or empty search passes through untouched
    if (!up_data.found && (up_data.lo < up_data.hi)) begin
      if (up_data.cp > span.hi) begin
        step_next.lo = mid + 1'b1;
      end else if (up_data.cp < span.lo) begin
        step_next.hi = mid;
      end else begin
        step_next.found = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      down_valid <= 1'b0;
    end else if (load) begin
      down_valid <= 1'b1;
    end else if (down_ready) begin
      down_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      down_data <= step_next;
    end
  end

endmodule
`default_nettype wire

// ===== src/ucw_classify.sv =====
// ucw_classify: final stage, folds NUL, controls, table hit and wide ranges
// into the column width and holds it in the output register. depends on ucw_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ucw_classify (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               wide_en,
  input  wire logic               up_valid,
  output logic                    up_ready,
  input  wire ucw_pkg::ucw_srch_t up_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [2:0]       column_width
);

  logic [ucw_pkg::CP_W-1:0] cp;
  logic                     is_ctrl;
  logic                     is_wide;
  logic signed [2:0]        width_next;
  logic                     load;

  assign up_ready = !out_valid || out_ready;
  assign load     = up_valid && up_ready;
  assign cp       = up_data.cp;

  always_comb begin
    is_ctrl = (cp < 21'h00020) || ((cp >= 21'h0007F) && (cp < 21'h000A0));
    is_wide = ((cp >= 21'h01100) && (cp <= 21'h0115F))
           || (cp == 21'h02329) || (cp == 21'h0232A)
           || ((cp >= 21'h02E80) && (cp <= 21'h0A4CF) && (cp != 21'h0303F))
           || ((cp >= 21'h0AC00) && (cp <= 21'h0D7A3))
           || ((cp >= 21'h0F900) && (cp <= 21'h0FAFF))
           || ((cp >= 21'h0FE10) && (cp <= 21'h0FE19))
           || ((cp >= 21'h0FE30) && (cp <= 21'h0FE6F))
           || ((cp >= 21'h0FF00) && (cp <= 21'h0FF60))
           || ((cp >= 21'h0FFE0) && (cp <= 21'h0FFE6))
           || (wide_en && (cp >= 21'h20000) && (cp <= 21'h2FFFD))
           || (wide_en && (cp >= 21'h30000) && (cp <= 21'h3FFFD));
    if (cp == '0) begin
      width_next = ucw_pkg::WIDTH_ZERO;
    end else if (is_ctrl) begin
      width_next = ucw_pkg::WIDTH_CTRL;
    end else if (up_data.found) begin
      width_next = ucw_pkg::WIDTH_ZERO;
    end else if (is_wide) begin
      width_next = ucw_pkg::WIDTH_TWO;
    end else begin
      width_next = ucw_pkg::WIDTH_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      column_width <= width_next;
    end
  end

endmodule
`default_nettype wire

// ===== verif/tb_unicode_column_width.sv =====
// tb_unicode_column_width: self-checking testbench for the column width pipeline.
// drives code points through valid/ready with random gaps and stalls and checks
// each width against a local predictor. depends on ucw_pkg and unicode_column_width.
`timescale 1ns / 1ps

module tb_unicode_column_width;

  localparam int CLK_HALF    = 4;
  localparam int RESET_CYCLES = 9;
  localparam int PIPE_LATENCY = 9;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int SPAN_COUNT   = 142;
  localparam int MAX_GAP      = 17;
  localparam int PHASE_ITEMS  = 200;
  localparam int PHASE_COUNT  = 6;

  // non-spacing intervals as {lo, hi}, sorted and disjoint; kept here on its own
  // so that a slip in the design's copy of the table shows up as a mismatch
  localparam logic [41:0] ZERO_SPANS [SPAN_COUNT] = '{
    {21'h00300, 21'h0036F}, {21'h00483, 21'h00486}, {21'h00488, 21'h00489},
    {21'h00591, 21'h005BD}, {21'h005BF, 21'h005BF}, {21'h005C1, 21'h005C2},
    {21'h005C4, 21'h005C5}, {21'h005C7, 21'h005C7}, {21'h00600, 21'h00603},
    {21'h00610, 21'h00615}, {21'h0064B, 21'h0065E}, {21'h00670, 21'h00670},
    {21'h006D6, 21'h006E4}, {21'h006E7, 21'h006E8}, {21'h006EA, 21'h006ED},
    {21'h0070F, 21'h0070F}, {21'h00711, 21'h00711}, {21'h00730, 21'h0074A},
    {21'h007A6, 21'h007B0}, {21'h007EB, 21'h007F3}, {21'h00901, 21'h00902},
    {21'h0093C, 21'h0093C}, {21'h00941, 21'h00948}, {21'h0094D, 21'h0094D},
    {21'h00951, 21'h00954}, {21'h00962, 21'h00963}, {21'h00981, 21'h00981},
    {21'h009BC, 21'h009BC}, {21'h009C1, 21'h009C4}, {21'h009CD, 21'h009CD},
    {21'h009E2, 21'h009E3}, {21'h00A01, 21'h00A02}, {21'h00A3C, 21'h00A3C},
    {21'h00A41, 21'h00A42}, {21'h00A47, 21'h00A48}, {21'h00A4B, 21'h00A4D},
    {21'h00A70, 21'h00A71}, {21'h00A81, 21'h00A82}, {21'h00ABC, 21'h00ABC},
    {21'h00AC1, 21'h00AC5}, {21'h00AC7, 21'h00AC8}, {21'h00ACD, 21'h00ACD},
    {21'h00AE2, 21'h00AE3}, {21'h00B01, 21'h00B01}, {21'h00B3C, 21'h00B3C},
    {21'h00B3F, 21'h00B3F}, {21'h00B41, 21'h00B43}, {21'h00B4D, 21'h00B4D},
    {21'h00B56, 21'h00B56}, {21'h00B82, 21'h00B82}, {21'h00BC0, 21'h00BC0},
    {21'h00BCD, 21'h00BCD}, {21'h00C3E, 21'h00C40}, {21'h00C46, 21'h00C48},
    {21'h00C4A, 21'h00C4D}, {21'h00C55, 21'h00C56}, {21'h00CBC, 21'h00CBC},
    {21'h00CBF, 21'h00CBF}, {21'h00CC6, 21'h00CC6}, {21'h00CCC, 21'h00CCD},
    {21'h00CE2, 21'h00CE3}, {21'h00D41, 21'h00D43}, {21'h00D4D, 21'h00D4D},
    {21'h00DCA, 21'h00DCA}, {21'h00DD2, 21'h00DD4}, {21'h00DD6, 21'h00DD6},
    {21'h00E31, 21'h00E31}, {21'h00E34, 21'h00E3A}, {21'h00E47, 21'h00E4E},
    {21'h00EB1, 21'h00EB1}, {21'h00EB4, 21'h00EB9}, {21'h00EBB, 21'h00EBC},
    {21'h00EC8, 21'h00ECD}, {21'h00F18, 21'h00F19}, {21'h00F35, 21'h00F35},
    {21'h00F37, 21'h00F37}, {21'h00F39, 21'h00F39}, {21'h00F71, 21'h00F7E},
    {21'h00F80, 21'h00F84}, {21'h00F86, 21'h00F87}, {21'h00F90, 21'h00F97},
    {21'h00F99, 21'h00FBC}, {21'h00FC6, 21'h00FC6}, {21'h0102D, 21'h01030},
    {21'h01032, 21'h01032}, {21'h01036, 21'h01037}, {21'h01039, 21'h01039},
    {21'h01058, 21'h01059}, {21'h01160, 21'h011FF}, {21'h0135F, 21'h0135F},
    {21'h01712, 21'h01714}, {21'h01732, 21'h01734}, {21'h01752, 21'h01753},
    {21'h01772, 21'h01773}, {21'h017B4, 21'h017B5}, {21'h017B7, 21'h017BD},
    {21'h017C6, 21'h017C6}, {21'h017C9, 21'h017D3}, {21'h017DD, 21'h017DD},
    {21'h0180B, 21'h0180D}, {21'h018A9, 21'h018A9}, {21'h01920, 21'h01922},
    {21'h01927, 21'h01928}, {21'h01932, 21'h01932}, {21'h01939, 21'h0193B},
    {21'h01A17, 21'h01A18}, {21'h01B00, 21'h01B03}, {21'h01B34, 21'h01B34},
    {21'h01B36, 21'h01B3A}, {21'h01B3C, 21'h01B3C}, {21'h01B42, 21'h01B42},
    {21'h01B6B, 21'h01B73}, {21'h01DC0, 21'h01DCA}, {21'h01DFE, 21'h01DFF},
    {21'h0200B, 21'h0200F}, {21'h0202A, 21'h0202E}, {21'h02060, 21'h02063},
    {21'h0206A, 21'h0206F}, {21'h020D0, 21'h020EF}, {21'h0302A, 21'h0302F},
    {21'h03099, 21'h0309A}, {21'h0A806, 21'h0A806}, {21'h0A80B, 21'h0A80B},
    {21'h0A825, 21'h0A826}, {21'h0FB1E, 21'h0FB1E}, {21'h0FE00, 21'h0FE0F},
    {21'h0FE20, 21'h0FE23}, {21'h0FEFF, 21'h0FEFF}, {21'h0FFF9, 21'h0FFFB},
    {21'h10A01, 21'h10A03}, {21'h10A05, 21'h10A06}, {21'h10A0C, 21'h10A0F},
    {21'h10A38, 21'h10A3A}, {21'h10A3F, 21'h10A3F}, {21'h1D167, 21'h1D169},
    {21'h1D173, 21'h1D182}, {21'h1D185, 21'h1D18B}, {21'h1D1AA, 21'h1D1AD},
    {21'h1D242, 21'h1D244}, {21'hE0001, 21'hE0001}, {21'hE0020, 21'hE007F},
    {21'hE0100, 21'hE01EF}
  };

  // boundaries of the control, wide and beyond-unicode ranges, plus 0E001, 0E020 and
  // 0E100; some random items land on one of these or a neighbour
  localparam logic [20:0] RANGE_EDGES [30] = '{
    21'h00020, 21'h0007F, 21'h000A0, 21'h01100, 21'h0115F, 21'h02329, 21'h0232A,
    21'h02E80, 21'h0303F, 21'h0A4CF, 21'h0AC00, 21'h0D7A3, 21'h0F900, 21'h0FAFF,
    21'h0FE10, 21'h0FE19, 21'h0FE30, 21'h0FE6F, 21'h0FF00, 21'h0FF60, 21'h0FFE0,
    21'h0FFE6, 21'h20000, 21'h2FFFD, 21'h30000, 21'h3FFFD, 21'h110000, 21'h0E001,
    21'h0E020, 21'h0E100
  };

  // short directed list: controls, table ends, wide range ends, surrogates,
  // noncharacters, the optional planes, the tag block and the top of the field
  localparam logic [20:0] DIRECTED_POINTS [25] = '{
    21'h00000, 21'h00001, 21'h0001F, 21'h0007F, 21'h0009F, 21'h000A0, 21'h00300,
    21'h00370, 21'h01100, 21'h01160, 21'h02329, 21'h02E80, 21'h0303F, 21'h0A4D0,
    21'h0D7A3, 21'h0D800, 21'h0FFFF, 21'h20000, 21'h2FFFE, 21'h3FFFD, 21'hE0001,
    21'hE01EF, 21'h0E001, 21'h10FFFF, 21'h1FFFFF
  };

  // expected widths in arrival order, plus the predictor and its copy of the
  // wide planes switch
  class width_scoreboard;
    logic signed [2:0] width_q[$];
    logic [20:0]       point_q[$];
    bit                wide_planes;
    int                errors;

    function new();
      wide_planes = 1'b1;
      errors = 0;
    endfunction

    function void set_wide_planes(bit v);
      wide_planes = v;
    endfunction

    function logic signed [2:0] predict_width(logic [20:0] cp);
      bit wide;
      if (cp == 21'h0) return ucw_pkg::WIDTH_ZERO;
      if (cp < 21'h20 || (cp >= 21'h7F && cp < 21'hA0)) return ucw_pkg::WIDTH_CTRL;
      // linear scan gives the same answer as a binary search on a sorted,
      // disjoint table
      for (int i = 0; i < SPAN_COUNT; i++) begin
        if (cp >= ZERO_SPANS[i][41:21] && cp <= ZERO_SPANS[i][20:0]) begin
          return ucw_pkg::WIDTH_ZERO;
        end
      end
      wide = (cp >= 21'h1100 && cp <= 21'h115F) || cp == 21'h2329 || cp == 21'h232A
          || (cp >= 21'h2E80 && cp <= 21'hA4CF && cp != 21'h303F)
          || (cp >= 21'hAC00 && cp <= 21'hD7A3) || (cp >= 21'hF900 && cp <= 21'hFAFF)
          || (cp >= 21'hFE10 && cp <= 21'hFE19) || (cp >= 21'hFE30 && cp <= 21'hFE6F)
          || (cp >= 21'hFF00 && cp <= 21'hFF60) || (cp >= 21'hFFE0 && cp <= 21'hFFE6)
          || (wide_planes && ((cp >= 21'h20000 && cp <= 21'h2FFFD)
                           || (cp >= 21'h30000 && cp <= 21'h3FFFD)));
      return wide ? ucw_pkg::WIDTH_TWO : ucw_pkg::WIDTH_ONE;
    endfunction

    function void note_code_point(logic [20:0] cp);
      point_q.push_back(cp);
      width_q.push_back(predict_width(cp));
    endfunction

    function void check_width(logic signed [2:0] got);
      logic signed [2:0] want;
      logic [20:0]       cp;
      if (width_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0d", $time, got);
        errors++;
        return;
      end
      want = width_q.pop_front();
      cp = point_q.pop_front();
      if (got !== want) begin
        $display("%0t: width of %h: expected %0d, actual %0d", $time, cp, want, got);
        errors++;
      end
    endfunction

    function int pending();
      return width_q.size();
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic               cfg_wdata;
  logic               in_valid;
  logic               in_ready;
  logic [20:0]        code_point;
  logic               out_valid;
  logic               out_ready;
  logic signed [2:0]  column_width;

  width_scoreboard    sb;
  int unsigned        cycle_count;
  bit                 no_idle;   // both sides run flat out while set

  unicode_column_width u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .code_point   (code_point),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .column_width (column_width)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // watchdog: ends the run with a failure once the cycle limit is reached
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_unicode_column_width: FAIL");
      $finish;
    end
  end

  // pick a code point: often near the edges where the width changes, otherwise from
  // fixed ranges or fully random values so that every input bit toggles
  function automatic logic [20:0] pick_code_point();
    int unsigned span;
    logic [20:0] base;
    case ($urandom_range(0, 9))
      0: return 21'($urandom_range(0, 21'h1FFFFF));
      1: return 21'($urandom_range(0, 21'hFF));
      2, 3, 4: begin
        span = $urandom_range(0, SPAN_COUNT - 1);
        case ($urandom_range(0, 4))
          0: return ZERO_SPANS[span][41:21] - 21'd1;
          1: return ZERO_SPANS[span][41:21];
          2: return 21'($urandom_range(ZERO_SPANS[span][41:21], ZERO_SPANS[span][20:0]));
          3: return ZERO_SPANS[span][20:0];
          default: return ZERO_SPANS[span][20:0] + 21'd1;
        endcase
      end
      5, 6: begin
        base = RANGE_EDGES[$urandom_range(0, 29)];
        return base + 21'($urandom_range(0, 2)) - 21'd1;
      end
      7: return 21'($urandom_range(0, 21'hFFFF));
      8: return 21'($urandom_range(21'h1F000, 21'h40010));
      default: return 21'($urandom_range(21'hE0000, 21'hE0200));
    endcase
  endfunction

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  // present one item after a random gap and hold it until it is taken
  task automatic send_item(logic [20:0] cp);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    code_point <= cp;
    do @(posedge clk); while (!in_ready);
    sb.note_code_point(cp);
  endtask

  // drop valid after the last item of a phase and wait for every width back
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // single-cycle register write; only done with the pipeline empty
  task automatic write_wide_planes(bit v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    sb.set_wide_planes(v);
    cfg_we <= 1'b0;
  endtask

  // result side: random stall before each item, then hold ready until taken
  initial begin
    int stall;
    out_ready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      sb.check_width(column_width);
    end
  end

  // main sequence
  initial begin
    sb = new();
    cycle_count <= 0;
    no_idle     <= 1'b0;
    rst         <= 1'b1;
    cfg_we      <= 1'b0;
    cfg_wdata   <= 1'b0;
    in_valid    <= 1'b0;
    code_point  <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed list first with the reset value of the switch, then with it off
    foreach (DIRECTED_POINTS[i]) send_item(DIRECTED_POINTS[i]);
    drain();
    write_wide_planes(1'b0);
    foreach (DIRECTED_POINTS[i]) send_item(DIRECTED_POINTS[i]);
    drain();

    // random phases; the switch alternates, with one redundant write of 1
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      write_wide_planes((ph % 3) != 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // every forty items decide whether the next stretch runs without gaps
        if (n % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
        send_item(pick_code_point());
      end
      no_idle = 1'b0;
      drain();
    end

    // let any stray result surface before the verdict
    repeat (PIPE_LATENCY + 8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_unicode_column_width: PASS");
    end else begin
      $display("tb_unicode_column_width: FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/ucw_pkg.sv
src/ucw_search_stage.sv
src/ucw_classify.sv
src/unicode_column_width.sv
verif/tb_unicode_column_width.sv
